[sv/mmp_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mmp_pkg
// Shared constants and register codes of the Michaelis-Menten propensity block.
// ---------------------------------------------------------------------------
package mmp_pkg;

  localparam int REG_BITS      = 32;
  localparam int PROP_INT_BITS = 32;
  localparam logic [REG_BITS-1:0] REG_RESET = 32'h0001_0000;

  typedef enum logic {
    REG_HALF_SAT = 1'b0,
    REG_TURNOVER = 1'b1
  } reg_idx_t;

endpackage

[sv/mmp_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mmp_if
// Valid/ready channels carrying count transactions in and propensity results out.
// ---------------------------------------------------------------------------
interface mmp_in_if #(
  parameter int COUNT_BITS = 24
);
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] substrate_count;
  logic [COUNT_BITS-1:0] enzyme_count;

  modport source (output valid, output substrate_count, output enzyme_count, input ready);
  modport sink   (input valid, input substrate_count, input enzyme_count, output ready);
endinterface

interface mmp_out_if #(
  parameter int COUNT_BITS = 24,
  parameter int FRAC_BITS  = 16
);
  logic                                          valid;
  logic                                          ready;
  logic [mmp_pkg::PROP_INT_BITS+FRAC_BITS-1:0]   propensity;
  logic [COUNT_BITS+FRAC_BITS-1:0]               free_substrate;
  logic                                          saturated;

  modport source (output valid, output propensity, output free_substrate, output saturated,
                  input ready);
  modport sink   (input valid, input propensity, input free_substrate, input saturated,
                  output ready);
endinterface

[sv/michaelis_menten_propensity_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// michaelis_menten_propensity_top
// Pipelined quasi-steady-state Michaelis-Menten propensity: square root and
// division are unrolled one bit per stage.
// ---------------------------------------------------------------------------
//  channel   | direction | handshake           | payload
//  in_ch     | in        | valid/ready         | substrate_count, enzyme_count
//  out_ch    | out       | valid/ready         | propensity, free_substrate, saturated
//  apb port  | in/out    | psel/penable/pready | Km at 0x0, kcat at 0x4
//
//  one transaction per cycle sustained while the skid register is empty; the difference,
//  denominator and divider remainder are W = max(32, COUNT_BITS+FRAC_BITS) + 1 bits wide
//  synchronous active-low reset clears all valid bits and loads 1.0 into both registers
//  a stalled output is caught in a skid register; the pipeline freezes only while
//  that register is full, so nothing is dropped or repeated
// ---------------------------------------------------------------------------
module michaelis_menten_propensity_top #(
  parameter int COUNT_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  mmp_in_if.sink       in_ch,
  mmp_out_if.source    out_ch,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int C    = COUNT_BITS;
  localparam int F    = FRAC_BITS;
  localparam int CF   = C + F;
  localparam int W    = ((CF > mmp_pkg::REG_BITS) ? CF : mmp_pkg::REG_BITS) + 1;
  localparam int KW   = mmp_pkg::REG_BITS + C;
  localparam int H    = (W + 1) / 2;
  localparam int L    = W - H;
  localparam int RB   = W + 1;
  localparam int RE   = 2 * RB;
  localparam int KH   = (KW + 1) / 2;
  localparam int KL   = KW - KH;
  localparam int SH   = (CF + 1) / 2;
  localparam int SL   = CF - SH;
  localparam int NW   = KW + CF;
  localparam int P    = mmp_pkg::PROP_INT_BITS + F;
  localparam int NHW  = NW - P;
  localparam int CMPW = (NHW > W) ? NHW : W;

  // ---------------- configuration ----------------
  logic [mmp_pkg::REG_BITS-1:0] km_r, kc_r;
  mmp_pkg::reg_idx_t            wr_idx;

  assign pready = 1'b1;
  assign wr_idx = mmp_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      km_r <= mmp_pkg::REG_RESET;
      kc_r <= mmp_pkg::REG_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (wr_idx)
        mmp_pkg::REG_HALF_SAT: km_r <= pwdata;
        mmp_pkg::REG_TURNOVER: kc_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (mmp_pkg::reg_idx_t'(paddr[2]))
      mmp_pkg::REG_HALF_SAT: prdata = km_r;
      mmp_pkg::REG_TURNOVER: prdata = kc_r;
      default:               prdata = km_r;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic sk_v_r, out_v_r;
  logic en;

  assign en          = !sk_v_r;
  assign in_ch.ready = en;

  // stage 1: input capture
  logic         s1_v_r;
  logic [C-1:0] s1_s_r, s1_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (en) s1_v_r <= in_ch.valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_s_r <= in_ch.substrate_count;
      s1_e_r <= in_ch.enzyme_count;
    end
  end

  // stage 2: difference magnitude and the two narrow products
  logic          s2_v_r, s2_dpos_r;
  logic [W-1:0]  s2_dmag_r;
  logic [KW-1:0] s2_kms_r, s2_kce_r;
  logic [W-1:0]  pos_w, neg_w;

  assign pos_w = W'({s1_s_r, {F{1'b0}}});
  assign neg_w = W'(km_r) + W'({s1_e_r, {F{1'b0}}});

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (en) s2_v_r <= s1_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2_dpos_r <= (pos_w >= neg_w);
      s2_dmag_r <= (pos_w >= neg_w) ? (pos_w - neg_w) : (neg_w - pos_w);
      s2_kms_r  <= KW'(km_r) * KW'(s1_s_r);
      s2_kce_r  <= KW'(kc_r) * KW'(s1_e_r);
    end
  end

  // stage 3: partial products of the square
  logic             s3_v_r, s3_dpos_r;
  logic [W-1:0]     s3_dmag_r;
  logic [KW-1:0]    s3_kms_r, s3_kce_r;
  logic [2*H-1:0]   s3_ll_r;
  logic [H+L-1:0]   s3_lh_r;
  logic [2*L-1:0]   s3_hh_r;
  logic [H-1:0]     dlo;
  logic [L-1:0]     dhi;

  assign dlo = s2_dmag_r[H-1:0];
  assign dhi = s2_dmag_r[W-1:H];

  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (en) s3_v_r <= s2_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_dpos_r <= s2_dpos_r;
      s3_dmag_r <= s2_dmag_r;
      s3_kms_r  <= s2_kms_r;
      s3_kce_r  <= s2_kce_r;
      s3_ll_r   <= (2*H)'(dlo) * (2*H)'(dlo);
      s3_lh_r   <= (H+L)'(dlo) * (H+L)'(dhi);
      s3_hh_r   <= (2*L)'(dhi) * (2*L)'(dhi);
    end
  end

  // stage 4: square sum
  logic          s4_v_r, s4_dpos_r;
  logic [W-1:0]  s4_dmag_r;
  logic [KW-1:0] s4_kms_r, s4_kce_r;
  logic [RE-1:0] s4_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else if (en) s4_v_r <= s3_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s4_dpos_r <= s3_dpos_r;
      s4_dmag_r <= s3_dmag_r;
      s4_kms_r  <= s3_kms_r;
      s4_kce_r  <= s3_kce_r;
      // cross term appears twice, hence the extra shift
      s4_sq_r   <= RE'(s3_ll_r) + (RE'(s3_lh_r) << (H + 1)) + (RE'(s3_hh_r) << (2 * H));
    end
  end

  // stage 5 feeds the root chain: radicand = d^2 + 4*Km*S
  logic          sq_v_r    [0:RB];
  logic          sq_dpos_r [0:RB];
  logic [W-1:0]  sq_dmag_r [0:RB];
  logic [KW-1:0] sq_kce_r  [0:RB];
  logic [RE-1:0] sq_rem_r  [0:RB];
  logic [RB-1:0] sq_root_r [0:RB];

  always_ff @(posedge clk) begin
    if (!rst_n) sq_v_r[0] <= 1'b0;
    else if (en) sq_v_r[0] <= s4_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sq_dpos_r[0] <= s4_dpos_r;
      sq_dmag_r[0] <= s4_dmag_r;
      sq_kce_r[0]  <= s4_kce_r;
      sq_rem_r[0]  <= s4_sq_r + (RE'(s4_kms_r) << (F + 2));
      sq_root_r[0] <= '0;
    end
  end

  // restoring square root, one result bit per stage
  for (genvar k = 0; k < RB; k++) begin : g_sqrt
    localparam int B = RB - 1 - k;
    localparam logic [RE-1:0] ONE_RE = RE'(1);
    localparam logic [RB-1:0] ONE_RB = RB'(1);
    logic [RE-1:0] trial;
    logic          take;

    assign trial = (RE'(sq_root_r[k]) << (B + 1)) | (ONE_RE << (2 * B));
    assign take  = (sq_rem_r[k] >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[k+1] <= 1'b0;
      else if (en) sq_v_r[k+1] <= sq_v_r[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_dpos_r[k+1] <= sq_dpos_r[k];
        sq_dmag_r[k+1] <= sq_dmag_r[k];
        sq_kce_r[k+1]  <= sq_kce_r[k];
        sq_rem_r[k+1]  <= take ? (sq_rem_r[k] - trial) : sq_rem_r[k];
        sq_root_r[k+1] <= take ? (sq_root_r[k] | (ONE_RB << B)) : sq_root_r[k];
      end
    end
  end

  // stage A: free substrate
  logic          sa_v_r;
  logic [CF-1:0] sa_sfree_r;
  logic [KW-1:0] sa_kce_r;
  logic [RB:0]   sf_sum;

  assign sf_sum = sq_dpos_r[RB] ? ((RB+1)'(sq_dmag_r[RB]) + (RB+1)'(sq_root_r[RB]))
                                : ((RB+1)'(sq_root_r[RB]) - (RB+1)'(sq_dmag_r[RB]));

  always_ff @(posedge clk) begin
    if (!rst_n) sa_v_r <= 1'b0;
    else if (en) sa_v_r <= sq_v_r[RB];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sa_sfree_r <= sf_sum[CF:1];
      sa_kce_r   <= sq_kce_r[RB];
    end
  end

  // stage B: denominator and numerator partial products
  logic             sb_v_r;
  logic [CF-1:0]    sb_sfree_r;
  logic [W-1:0]     sb_den_r;
  logic [KH+SH-1:0] sb_p00_r;
  logic [KH+SL-1:0] sb_p01_r;
  logic [KL+SH-1:0] sb_p10_r;
  logic [KL+SL-1:0] sb_p11_r;
  logic [KH-1:0]    k_lo;
  logic [KL-1:0]    k_hi;
  logic [SH-1:0]    f_lo;
  logic [SL-1:0]    f_hi;

  assign k_lo = sa_kce_r[KH-1:0];
  assign k_hi = sa_kce_r[KW-1:KH];
  assign f_lo = sa_sfree_r[SH-1:0];
  assign f_hi = sa_sfree_r[CF-1:SH];

  always_ff @(posedge clk) begin
    if (!rst_n) sb_v_r <= 1'b0;
    else if (en) sb_v_r <= sa_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sb_sfree_r <= sa_sfree_r;
      sb_den_r   <= W'(km_r) + W'(sa_sfree_r);
      sb_p00_r   <= (KH+SH)'(k_lo) * (KH+SH)'(f_lo);
      sb_p01_r   <= (KH+SL)'(k_lo) * (KH+SL)'(f_hi);
      sb_p10_r   <= (KL+SH)'(k_hi) * (KL+SH)'(f_lo);
      sb_p11_r   <= (KL+SL)'(k_hi) * (KL+SL)'(f_hi);
    end
  end

  // stage C: numerator kcat*E*sFree
  logic          sc_v_r;
  logic [CF-1:0] sc_sfree_r;
  logic [W-1:0]  sc_den_r;
  logic [NW-1:0] sc_num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) sc_v_r <= 1'b0;
    else if (en) sc_v_r <= sb_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sc_sfree_r <= sb_sfree_r;
      sc_den_r   <= sb_den_r;
      sc_num_r   <= NW'(sb_p00_r) + (NW'(sb_p01_r) << SH) + (NW'(sb_p10_r) << KH)
                    + (NW'(sb_p11_r) << (KH + SH));
    end
  end

  // stage D: overflow test seeds the divider
  logic          dv_v_r     [0:P];
  logic          dv_sat_r   [0:P];
  logic          dv_zero_r  [0:P];
  logic [CF-1:0] dv_sfree_r [0:P];
  logic [W-1:0]  dv_den_r   [0:P];
  logic [W-1:0]  dv_rem_r   [0:P];
  logic [P-1:0]  dv_qn_r    [0:P];
  logic [CMPW-1:0] numhi_x;

  // quotient fits iff the numerator bits above the result width stay below den
  assign numhi_x = CMPW'(sc_num_r[NW-1:P]);

  always_ff @(posedge clk) begin
    if (!rst_n) dv_v_r[0] <= 1'b0;
    else if (en) dv_v_r[0] <= sc_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dv_sat_r[0]   <= (numhi_x >= CMPW'(sc_den_r));
      dv_zero_r[0]  <= (sc_den_r == '0);
      dv_sfree_r[0] <= sc_sfree_r;
      dv_den_r[0]   <= sc_den_r;
      dv_rem_r[0]   <= numhi_x[W-1:0];
      dv_qn_r[0]    <= sc_num_r[P-1:0];
    end
  end

  // restoring divider, one quotient bit per stage; qn shifts numerator out, quotient in
  for (genvar j = 0; j < P; j++) begin : g_div
    logic [W:0] part;
    logic       take;

    assign part = {dv_rem_r[j], dv_qn_r[j][P-1]};
    assign take = (part >= {1'b0, dv_den_r[j]});

    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[j+1] <= 1'b0;
      else if (en) dv_v_r[j+1] <= dv_v_r[j];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_sat_r[j+1]   <= dv_sat_r[j];
        dv_zero_r[j+1]  <= dv_zero_r[j];
        dv_sfree_r[j+1] <= dv_sfree_r[j];
        dv_den_r[j+1]   <= dv_den_r[j];
        dv_rem_r[j+1]   <= take ? W'(part - {1'b0, dv_den_r[j]}) : part[W-1:0];
        dv_qn_r[j+1]    <= {dv_qn_r[j][P-2:0], take};
      end
    end
  end

  // ---------------- output register and skid ----------------
  logic [P-1:0]  tail_prop;
  logic          tail_sat;
  logic [P-1:0]  out_prop_r, sk_prop_r;
  logic [CF-1:0] out_sf_r, sk_sf_r;
  logic          out_sat_r, sk_sat_r;

  assign tail_sat  = dv_sat_r[P] && !dv_zero_r[P];
  assign tail_prop = dv_zero_r[P] ? '0 : (dv_sat_r[P] ? '1 : dv_qn_r[P]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else begin
      priority if (sk_v_r) begin
        if (out_ch.ready) begin
          out_prop_r <= sk_prop_r;
          out_sf_r   <= sk_sf_r;
          out_sat_r  <= sk_sat_r;
          sk_v_r     <= 1'b0;
        end
      end else if (dv_v_r[P]) begin
        if (!out_v_r || out_ch.ready) begin
          out_prop_r <= tail_prop;
          out_sf_r   <= dv_sfree_r[P];
          out_sat_r  <= tail_sat;
          out_v_r    <= 1'b1;
        end else begin
          sk_prop_r <= tail_prop;
          sk_sf_r   <= dv_sfree_r[P];
          sk_sat_r  <= tail_sat;
          sk_v_r    <= 1'b1;
        end
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.propensity     = out_prop_r;
  assign out_ch.free_substrate = out_sf_r;
  assign out_ch.saturated      = out_sat_r;

  // ---------------- assertions ----------------
  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    sk_v_r |-> out_v_r)
    else $error("skid holds a result while the output register is empty");

  a_sat_is_max : assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.saturated) |-> (out_ch.propensity == '1))
    else $error("saturated result is not at full scale");

  a_no_substrate : assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.free_substrate == '0) |->
      (out_ch.propensity == '0 && !out_ch.saturated))
    else $error("nonzero propensity with no free substrate");

endmodule
